// File: hdl/mi3_pkg.sv
package mi3_pkg;

  localparam int WORD_BITS_DEF = 32;
  localparam int FRAC_BITS_DEF = 16;
  localparam int N = 3;

  typedef struct packed {
    logic valid;
    logic sing;
  } ctl_t;

  function automatic int mi3_latency(input int word_bits, input int frac_bits);
    int ns;
    ns = (word_bits + frac_bits + 1) >> 1;
    return N * (ns + 5) + (N - 1) * 3 + 1;
  endfunction

endpackage

// File: hdl/matrix_inverse_3x3_gauss_jordan_unit.sv
// 3x3 matrix inverse, Gauss-Jordan, signed fixed point (Q16.16 by default).
// One matrix is taken on every clock edge where start is high and busy is
// low; busy is high only during reset, so a new matrix may follow in every
// cycle. Each result is marked by a one-cycle done pulse; it must be
// taken then, as the unit cannot be held off. The pipeline is made of
// the three pivot divisions, each a restoring divider that resolves two
// quotient bits per stage, followed by a three-stage multiply-subtract
// per elimination step. singular is raised with done when some column
// has no nonzero pivot, and r00..r22 are then 0.
module matrix_inverse_3x3_gauss_jordan_unit #(
  parameter int WORD_BITS = mi3_pkg::WORD_BITS_DEF,
  parameter int FRAC_BITS = mi3_pkg::FRAC_BITS_DEF
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  output logic                        busy,
  input  logic signed [WORD_BITS-1:0] m00,
  input  logic signed [WORD_BITS-1:0] m01,
  input  logic signed [WORD_BITS-1:0] m02,
  input  logic signed [WORD_BITS-1:0] m10,
  input  logic signed [WORD_BITS-1:0] m11,
  input  logic signed [WORD_BITS-1:0] m12,
  input  logic signed [WORD_BITS-1:0] m20,
  input  logic signed [WORD_BITS-1:0] m21,
  input  logic signed [WORD_BITS-1:0] m22,
  output logic                        done,
  output logic signed [WORD_BITS-1:0] r00,
  output logic signed [WORD_BITS-1:0] r01,
  output logic signed [WORD_BITS-1:0] r02,
  output logic signed [WORD_BITS-1:0] r10,
  output logic signed [WORD_BITS-1:0] r11,
  output logic signed [WORD_BITS-1:0] r12,
  output logic signed [WORD_BITS-1:0] r20,
  output logic signed [WORD_BITS-1:0] r21,
  output logic signed [WORD_BITS-1:0] r22,
  output logic                        singular
);
  import mi3_pkg::*;

  localparam int W  = WORD_BITS;
  localparam int NC = 2 * N;
  localparam int LS = 2 * N - 1;
  localparam logic signed [W-1:0] ONE = W'(1) << FRAC_BITS;

  logic signed [W-1:0] st [2*N][N][NC];
  ctl_t                ct [2*N];
  logic                ok;

  assign busy = rst;

  assign st[0][0][0] = m00;
  assign st[0][0][1] = m01;
  assign st[0][0][2] = m02;
  assign st[0][1][0] = m10;
  assign st[0][1][1] = m11;
  assign st[0][1][2] = m12;
  assign st[0][2][0] = m20;
  assign st[0][2][1] = m21;
  assign st[0][2][2] = m22;

  for (genvar i = 0; i < N; i++) begin : g_ident
    for (genvar k = N; k < NC; k++) begin : g_col
      assign st[0][i][k] = (k - N == i) ? ONE : '0;
    end
  end

  assign ct[0].valid = start & ~busy;
  assign ct[0].sing  = 1'b0;

  for (genvar c = 0; c < N; c++) begin : g_fwd
    mi3_fwd #(
      .WORD_BITS(WORD_BITS),
      .FRAC_BITS(FRAC_BITS),
      .COL      (c)
    ) u_fwd (
      .clk    (clk),
      .rst    (rst),
      .ctl_in (ct[c]),
      .w_in   (st[c]),
      .ctl_out(ct[c+1]),
      .w_out  (st[c+1])
    );
  end

  // clear above the pivots, last column first; only the right half is updated
  for (genvar s = 0; s < N - 1; s++) begin : g_bwd
    localparam int PC = N - 1 - s;
    logic signed [W-1:0] dl [3][N][NC];
    ctl_t                dc [3];

    always_ff @(posedge clk) begin
      dl[0] <= st[N+s];
      dl[1] <= dl[0];
      dl[2] <= dl[1];
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        dc[0] <= '0;
        dc[1] <= '0;
        dc[2] <= '0;
      end else begin
        dc[0] <= ct[N+s];
        dc[1] <= dc[0];
        dc[2] <= dc[1];
      end
    end

    assign ct[N+s+1] = dc[2];

    for (genvar i = 0; i < N; i++) begin : g_row
      for (genvar k = 0; k < NC; k++) begin : g_col
        if (i < PC && k >= N) begin : g_upd
          mi3_msub #(
            .WORD_BITS(WORD_BITS),
            .FRAC_BITS(FRAC_BITS)
          ) u_msub (
            .clk(clk),
            .a  (st[N+s][i][k]),
            .t  (st[N+s][i][PC]),
            .b  (st[N+s][PC][k]),
            .y  (st[N+s+1][i][k])
          );
        end else begin : g_hold
          assign st[N+s+1][i][k] = dl[2][i][k];
        end
      end
    end
  end

  assign ok = ct[LS].valid & ~ct[LS].sing;

  always_ff @(posedge clk) begin
    if (rst) begin
      done     <= 1'b0;
      singular <= 1'b0;
      r00      <= '0;
      r01      <= '0;
      r02      <= '0;
      r10      <= '0;
      r11      <= '0;
      r12      <= '0;
      r20      <= '0;
      r21      <= '0;
      r22      <= '0;
    end else begin
      done     <= ct[LS].valid;
      singular <= ct[LS].valid & ct[LS].sing;
      r00      <= ok ? st[LS][0][N]   : '0;
      r01      <= ok ? st[LS][0][N+1] : '0;
      r02      <= ok ? st[LS][0][N+2] : '0;
      r10      <= ok ? st[LS][1][N]   : '0;
      r11      <= ok ? st[LS][1][N+1] : '0;
      r12      <= ok ? st[LS][1][N+2] : '0;
      r20      <= ok ? st[LS][2][N]   : '0;
      r21      <= ok ? st[LS][2][N+1] : '0;
      r22      <= ok ? st[LS][2][N+2] : '0;
    end
  end

endmodule

// File: hdl/mi3_msub.sv
module mi3_msub #(
  parameter int WORD_BITS = mi3_pkg::WORD_BITS_DEF,
  parameter int FRAC_BITS = mi3_pkg::FRAC_BITS_DEF
) (
  input  logic                        clk,
  input  logic signed [WORD_BITS-1:0] a,
  input  logic signed [WORD_BITS-1:0] t,
  input  logic signed [WORD_BITS-1:0] b,
  output logic signed [WORD_BITS-1:0] y
);
  localparam int W  = WORD_BITS;
  localparam int F  = FRAC_BITS;
  localparam int H  = W / 2;
  localparam int L  = W - H;
  localparam int SW = 2 * W - F;
  localparam int DW = SW + 2;
  localparam logic signed [DW-1:0] DMAX = {{(DW-W+1){1'b0}}, {(W-1){1'b1}}};
  localparam logic signed [DW-1:0] DMIN = {{(DW-W+1){1'b1}}, {(W-1){1'b0}}};
  localparam logic signed [W-1:0]  MAXW = {1'b0, {(W-1){1'b1}}};
  localparam logic signed [W-1:0]  MINW = {1'b1, {(W-1){1'b0}}};

  logic [W-1:0]          mt;
  logic [W-1:0]          mb;
  logic [W+L-1:0]        plo;
  logic [W+H-1:0]        phi;
  logic                  n1;
  logic                  n2;
  logic signed [W-1:0]   a1;
  logic signed [W-1:0]   a2;
  logic [2*W-1:0]        prod;
  logic [SW-1:0]         sh;
  logic signed [DW-1:0]  ae;
  logic signed [DW-1:0]  se;
  logic signed [DW-1:0]  diff;

  assign mt = t[W-1] ? W'(-t) : W'(t);
  assign mb = b[W-1] ? W'(-b) : W'(b);

  always_ff @(posedge clk) begin
    plo <= mt * mb[L-1:0];
    phi <= mt * mb[W-1:L];
    n1  <= t[W-1] ^ b[W-1];
    a1  <= a;
  end

  assign prod = {phi, {L{1'b0}}} + {{H{1'b0}}, plo};

  always_ff @(posedge clk) begin
    sh <= prod[2*W-1:F];
    n2 <= n1;
    a2 <= a1;
  end

  assign ae   = $signed({{(DW-W){a2[W-1]}}, a2});
  assign se   = $signed({2'b00, sh});
  assign diff = n2 ? (ae + se) : (ae - se);

  always_ff @(posedge clk) begin
    if (diff > DMAX) begin
      y <= MAXW;
    end else if (diff < DMIN) begin
      y <= MINW;
    end else begin
      y <= diff[W-1:0];
    end
  end

endmodule

// File: hdl/mi3_fwd.sv
module mi3_fwd #(
  parameter int WORD_BITS = mi3_pkg::WORD_BITS_DEF,
  parameter int FRAC_BITS = mi3_pkg::FRAC_BITS_DEF,
  parameter int COL       = 0
) (
  input  logic                        clk,
  input  logic                        rst,
  input  mi3_pkg::ctl_t               ctl_in,
  input  logic signed [WORD_BITS-1:0] w_in  [mi3_pkg::N][2*mi3_pkg::N],
  output mi3_pkg::ctl_t               ctl_out,
  output logic signed [WORD_BITS-1:0] w_out [mi3_pkg::N][2*mi3_pkg::N]
);
  import mi3_pkg::*;

  localparam int W  = WORD_BITS;
  localparam int F  = FRAC_BITS;
  localparam int NC = 2 * N;
  localparam int RW = $clog2(N);
  localparam int NQ = W + F;
  localparam int NS = (NQ + 1) / 2;
  localparam int AW = W + 1 + NQ;
  localparam logic signed [W-1:0] MAXW = {1'b0, {(W-1){1'b1}}};
  localparam logic signed [W-1:0] MINW = {1'b1, {(W-1){1'b0}}};
  localparam logic [NQ-1:0]       HALF = {{F{1'b0}}, 1'b1, {(W-1){1'b0}}};

  logic                  zero;
  logic                  found;
  logic [RW-1:0]         jsel;
  logic signed [W:0]     psum [NC];
  logic signed [W-1:0]   prow [NC];
  logic [W-1:0]          xm   [NC];

  logic signed [W-1:0]   dm   [NS+1][N][NC];
  ctl_t                  dc   [NS+1];
  logic [W-1:0]          ym   [NS];
  logic [AW-1:0]         acc  [NS+1][NC];
  logic [AW-1:0]         anext [NS][NC];

  logic signed [W-1:0]   nres [NC];
  logic signed [W-1:0]   nw   [N][NC];
  ctl_t                  nc;
  logic signed [W-1:0]   ew   [3][N][NC];
  ctl_t                  ec   [3];

  // pivot search: first lower row with a nonzero entry in this column
  assign zero = (w_in[COL][COL] == '0);

  always_comb begin
    found = 1'b0;
    jsel  = RW'(COL);
    for (int j = N - 1; j > COL; j--) begin
      if (w_in[j][COL] != '0) begin
        found = 1'b1;
        jsel  = RW'(j);
      end
    end
  end

  always_comb begin
    for (int k = 0; k < NC; k++) begin
      psum[k] = $signed({w_in[COL][k][W-1], w_in[COL][k]})
              + $signed({w_in[jsel][k][W-1], w_in[jsel][k]});
      if (!(zero && found)) begin
        prow[k] = w_in[COL][k];
      end else if (psum[k][W] != psum[k][W-1]) begin
        prow[k] = psum[k][W] ? MINW : MAXW;
      end else begin
        prow[k] = psum[k][W-1:0];
      end
      xm[k] = prow[k][W-1] ? W'(-prow[k]) : W'(prow[k]);
    end
  end

  // restoring division, two quotient bits per stage
  always_comb begin
    logic [AW-1:0] t;
    for (int s = 0; s < NS; s++) begin
      for (int k = 0; k < NC; k++) begin
        t = acc[s][k];
        for (int u = 0; u < 2; u++) begin
          if (2 * s + u < NQ) begin
            t = t << 1;
            if (t[AW-1:NQ] >= {1'b0, ym[s]}) begin
              t[AW-1:NQ] = t[AW-1:NQ] - {1'b0, ym[s]};
              t[0]       = 1'b1;
            end
          end
        end
        anext[s][k] = t;
      end
    end
  end

  always_comb begin
    logic [NQ-1:0] q;
    logic          neg;
    for (int k = 0; k < NC; k++) begin
      q   = acc[NS][k][NQ-1:0];
      neg = dm[NS][COL][k][W-1] ^ dm[NS][COL][COL][W-1];
      if (neg) begin
        nres[k] = (q > HALF) ? MINW : W'(-q[W-1:0]);
      end else begin
        nres[k] = (q >= HALF) ? MAXW : q[W-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < N; i++) begin
      for (int k = 0; k < NC; k++) begin
        dm[0][i][k] <= (i == COL) ? prow[k] : w_in[i][k];
      end
    end
    for (int k = 0; k < NC; k++) begin
      acc[0][k] <= {{(W+1){1'b0}}, xm[k], {F{1'b0}}};
    end
    ym[0] <= xm[COL];
    for (int s = 0; s < NS; s++) begin
      dm[s+1]  <= dm[s];
      acc[s+1] <= anext[s];
    end
    for (int s = 1; s < NS; s++) begin
      ym[s] <= ym[s-1];
    end
    for (int i = 0; i < N; i++) begin
      for (int k = 0; k < NC; k++) begin
        nw[i][k] <= (i == COL) ? nres[k] : dm[NS][i][k];
      end
    end
    ew[0] <= nw;
    ew[1] <= ew[0];
    ew[2] <= ew[1];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int s = 0; s <= NS; s++) begin
        dc[s] <= '0;
      end
      nc <= '0;
      for (int s = 0; s < 3; s++) begin
        ec[s] <= '0;
      end
    end else begin
      dc[0].valid <= ctl_in.valid;
      dc[0].sing  <= ctl_in.sing | (zero & ~found);
      for (int s = 0; s < NS; s++) begin
        dc[s+1] <= dc[s];
      end
      nc    <= dc[NS];
      ec[0] <= nc;
      ec[1] <= ec[0];
      ec[2] <= ec[1];
    end
  end

  assign ctl_out = ec[2];

  // eliminate below the pivot
  for (genvar i = 0; i < N; i++) begin : g_row
    for (genvar k = 0; k < NC; k++) begin : g_col
      if (i > COL && k >= COL) begin : g_upd
        mi3_msub #(
          .WORD_BITS(WORD_BITS),
          .FRAC_BITS(FRAC_BITS)
        ) u_msub (
          .clk(clk),
          .a  (nw[i][k]),
          .t  (nw[i][COL]),
          .b  (nw[COL][k]),
          .y  (w_out[i][k])
        );
      end else begin : g_hold
        assign w_out[i][k] = ew[2][i][k];
      end
    end
  end

endmodule

// File: hdl/mi3_chk.sv
module mi3_chk #(
  parameter int WORD_BITS = mi3_pkg::WORD_BITS_DEF,
  parameter int FRAC_BITS = mi3_pkg::FRAC_BITS_DEF
) (
  input logic                        clk,
  input logic                        rst,
  input logic                        start,
  input logic                        busy,
  input logic                        done,
  input logic                        singular,
  input logic signed [WORD_BITS-1:0] r00,
  input logic signed [WORD_BITS-1:0] r01,
  input logic signed [WORD_BITS-1:0] r02,
  input logic signed [WORD_BITS-1:0] r10,
  input logic signed [WORD_BITS-1:0] r11,
  input logic signed [WORD_BITS-1:0] r12,
  input logic signed [WORD_BITS-1:0] r20,
  input logic signed [WORD_BITS-1:0] r21,
  input logic signed [WORD_BITS-1:0] r22
);
  import mi3_pkg::*;

  localparam int LAT = mi3_latency(WORD_BITS, FRAC_BITS);

  a_done_lat: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(start && !busy, LAT))
    else $error("word out without a word in at the pipeline latency");

  a_sing_done: assert property (@(posedge clk) disable iff (rst)
    singular |-> done)
    else $error("singular raised outside a result");

  a_zero: assert property (@(posedge clk) disable iff (rst)
    (!done || singular) |-> (r00 == '0 && r01 == '0 && r02 == '0 &&
                             r10 == '0 && r11 == '0 && r12 == '0 &&
                             r20 == '0 && r21 == '0 && r22 == '0))
    else $error("result nonzero while idle or singular");

  a_rst: assert property (@(posedge clk)
    rst |=> (!done && !singular))
    else $error("result strobe after reset");

endmodule

bind matrix_inverse_3x3_gauss_jordan_unit mi3_chk #(
  .WORD_BITS(WORD_BITS),
  .FRAC_BITS(FRAC_BITS)
) u_mi3_chk (.*);

// File: tb/tb_top.sv
`timescale 1ns / 100ps

module tb_top;
  import mi3_pkg::*;

  localparam int WB = WORD_BITS_DEF;
  localparam int FB = FRAC_BITS_DEF;
  localparam int LAT = mi3_latency(WB, FB);
  localparam int WATCH_LIMIT = 4 * LAT + 200;
  localparam longint WMAX = 64'sd2147483647;
  localparam longint WMIN = -64'sd2147483648;
  localparam longint ONE = 64'sd65536;

  typedef logic signed [WB-1:0] word_t;
  typedef struct {
    word_t r[9];
    logic sing;
  } inverse_t;

  localparam word_t ONE_W = word_t'(ONE);
  localparam word_t MAX_W = word_t'(WMAX);
  localparam word_t MIN_W = word_t'(WMIN);

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic start = 1'b0;
  logic busy, done, singular;
  word_t m00 = '0, m01 = '0, m02 = '0, m10 = '0, m11 = '0, m12 = '0,
         m20 = '0, m21 = '0, m22 = '0;
  word_t r00, r01, r02, r10, r11, r12, r20, r21, r22;

  inverse_t pending_inverses[$];
  int errors = 0;
  int idle_cycles = 0;
  bit quiet_tail = 0;

  always #2 clk = ~clk;

  matrix_inverse_3x3_gauss_jordan_unit uut (
    .clk(clk), .rst(rst), .start(start), .busy(busy),
    .m00(m00), .m01(m01), .m02(m02), .m10(m10), .m11(m11), .m12(m12),
    .m20(m20), .m21(m21), .m22(m22),
    .done(done), .r00(r00), .r01(r01), .r02(r02), .r10(r10), .r11(r11),
    .r12(r12), .r20(r20), .r21(r21), .r22(r22), .singular(singular)
  );

  function automatic longint clamp_word(longint v);
    if (v > WMAX) return WMAX;
    if (v < WMIN) return WMIN;
    return v;
  endfunction

  function automatic longint scaled_product(longint a, longint b);
    logic signed [127:0] p;
    logic [127:0] q;
    p = 128'(signed'(a)) * 128'(signed'(b));
    q = (p < 0) ? -p : p;
    q = q >> FB;
    if (q > (128'd1 << 60)) q = 128'd1 << 60;
    return (p < 0) ? -longint'(q) : longint'(q);
  endfunction

  function automatic longint scaled_quotient(longint a, longint d);
    logic [127:0] x, y, q;
    x = (a < 0) ? -a : a;
    y = (d < 0) ? -d : d;
    q = (x << FB) / y;
    if (q > (128'd1 << 60)) q = 128'd1 << 60;
    return clamp_word(((a < 0) != (d < 0)) ? -longint'(q) : longint'(q));
  endfunction

  function automatic inverse_t invert_matrix(word_t m[9]);
    longint w[3][6];
    longint t;
    inverse_t res;
    int j;
    logic sing;
    sing = 0;
    for (int i = 0; i < 3; i++)
      for (int k = 0; k < 6; k++)
        w[i][k] = (k < 3) ? longint'(m[i*3+k]) : ((k - 3 == i) ? ONE : 0);
    for (int i = 0; i < 3 && !sing; i++) begin
      if (w[i][i] == 0) begin
        for (j = i + 1; j < 3; j++)
          if (w[j][i] != 0) break;
        if (j >= 3) sing = 1;
        else
          for (int k = 0; k < 6; k++) w[i][k] = clamp_word(w[i][k] + w[j][k]);
      end
      if (!sing) begin
        t = w[i][i];
        for (int k = 0; k < 6; k++) w[i][k] = scaled_quotient(w[i][k], t);
        for (int r = i + 1; r < 3; r++) begin
          t = w[r][i];
          for (int k = i; k < 6; k++)
            w[r][k] = clamp_word(w[r][k] - scaled_product(t, w[i][k]));
        end
      end
    end
    if (!sing)
      for (int i = 2; i >= 0; i--)
        for (int r = i - 1; r >= 0; r--) begin
          t = w[r][i];
          for (int k = i; k < 6; k++)
            w[r][k] = clamp_word(w[r][k] - scaled_product(t, w[i][k]));
        end
    for (int i = 0; i < 9; i++) res.r[i] = sing ? '0 : word_t'(w[i/3][i%3+3]);
    res.sing = sing;
    return res;
  endfunction

  task automatic send_matrix(word_t m[9], bit allow_gaps);
    if (allow_gaps && !quiet_tail && $urandom_range(0, 3) == 0) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 11)) @(posedge clk);
    end
    start <= 1'b1;
    {m00, m01, m02, m10, m11, m12, m20, m21, m22} <=
      {m[0], m[1], m[2], m[3], m[4], m[5], m[6], m[7], m[8]};
    @(posedge clk);
    while (busy) @(posedge clk);
    pending_inverses = {pending_inverses, invert_matrix(m)};
  endtask

  function automatic word_t rand_entry();
    case ($urandom_range(0, 7))
      0: return word_t'($urandom);
      1: return word_t'(WMAX);
      2: return word_t'(WMIN);
      3: return '0;
      4: return word_t'(longint'($urandom_range(0, 8)) * ONE - 4 * ONE);
      default: return word_t'(signed'($urandom_range(0, 1 << 20)) - (1 << 19));
    endcase
  endfunction

  task automatic test_directed();
    word_t m[9];
    m = '{ONE_W, 0, 0, 0, ONE_W, 0, 0, 0, ONE_W};              send_matrix(m, 0);
    m = '{2*ONE_W, 0, 0, 0, -4*ONE_W, 0, 0, 0, ONE_W/2};       send_matrix(m, 0);
    m = '{0, ONE_W, 0, ONE_W, 0, 0, 0, 0, ONE_W};              send_matrix(m, 0);
    m = '{0, ONE_W, 0, 0, 0, ONE_W, ONE_W, 0, 0};              send_matrix(m, 0);
    m = '{0, 0, 0, 0, 0, 0, 0, 0, 0};                          send_matrix(m, 0);
    m = '{ONE_W, 2*ONE_W, 3*ONE_W, 2*ONE_W, 4*ONE_W, 6*ONE_W, 0, 0, ONE_W};
    send_matrix(m, 0);
    m = '{ONE_W, 0, 0, 0, ONE_W, 0, 0, 0, 0};                  send_matrix(m, 0);
    m = '{MAX_W, MIN_W, MAX_W, MIN_W, MAX_W, MIN_W, MAX_W, MAX_W, MIN_W};
    send_matrix(m, 0);
    m = '{1, 0, 0, 0, 1, 0, 0, 0, -1};                         send_matrix(m, 0);
    m = '{MIN_W, 0, 0, 0, MAX_W, 0, 0, 0, MIN_W};              send_matrix(m, 0);
    m = '{-1, -1, -1, -1, -1, -1, -1, -1, -1};                 send_matrix(m, 0);
    m = '{2*ONE_W, ONE_W, ONE_W, ONE_W, 3*ONE_W, 2*ONE_W, ONE_W, 0, 0};
    send_matrix(m, 0);
    m = '{0, 0, ONE_W, 0, ONE_W, 0, ONE_W, 0, 0};              send_matrix(m, 0);
  endtask

  task automatic test_random(int count, bit allow_gaps);
    word_t m[9];
    for (int n = 0; n < count; n++) begin
      foreach (m[i]) m[i] = rand_entry();
      send_matrix(m, allow_gaps);
    end
  endtask

  always @(posedge clk) begin
    inverse_t exp_inv;
    word_t got[9];
    if (!rst && done) begin
      got = '{r00, r01, r02, r10, r11, r12, r20, r21, r22};
      if (pending_inverses.size() == 0) begin
        $error("result with no matrix outstanding");
        errors++;
      end else begin
        exp_inv = pending_inverses.pop_front();
        for (int i = 0; i < 9; i++)
          if (got[i] !== exp_inv.r[i]) begin
            $error("r%0d%0d expected %0d actual %0d", i/3, i%3, exp_inv.r[i], got[i]);
            errors++;
          end
        if (singular !== exp_inv.sing) begin
          $error("singular expected %0d actual %0d", exp_inv.sing, singular);
          errors++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst || done || (start && !busy)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCH_LIMIT) begin
      $display("matrix_inverse_3x3_gauss_jordan_unit verification failed");
      $finish;
    end
  end

  initial begin
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed();
    test_random(560, 1);
    quiet_tail = 1;
    test_random(140, 0);
    start <= 1'b0;
    while (pending_inverses.size() != 0) @(posedge clk);
    repeat (LAT + 10) @(posedge clk);
    if (errors == 0 && pending_inverses.size() == 0)
      $display("matrix_inverse_3x3_gauss_jordan_unit verification clean");
    else
      $display("matrix_inverse_3x3_gauss_jordan_unit verification failed");
    $finish;
  end
endmodule
